// ----- hw/rtl/qalu_pkg.sv -----
`timescale 1ns / 1ps
// qalu_pkg: shared types, constants and helpers of the quaternion arithmetic unit
// no dependencies; used by quaternion_alu, qalu_lane, qalu_div and qalu_sqrt
package qalu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_LANES     = 4;
	localparam int DIV_STEPS     = 32;
	localparam int SQRT_STEPS    = 31;
	localparam int PIPE_DEPTH    = DIV_STEPS + 3;
	localparam int SUM_W         = 66;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_SCALE,
		OP_DIV,
		OP_NSQ,
		OP_NORM,
		OP_NOP
	} op_t;

	// sign of each Hamilton product term, one row per result part, bit k = term k
	localparam logic [3:0] HAM_NEG [NUM_LANES] = '{4'b1110, 4'b0100, 4'b1000, 4'b0010};

	typedef struct packed {
		op_t                         op;
		logic [NUM_LANES-1:0][31:0]  mul_a;
		logic [NUM_LANES-1:0][31:0]  mul_b;
		logic [NUM_LANES-1:0]        mul_neg;
		logic signed [31:0]          add_a;
		logic signed [31:0]          add_b;
		logic signed [31:0]          div_num;
		logic signed [31:0]          div_den;
	} lane_req_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} sat_val_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] val;
		logic               sat;
		logic               dz;
	} lane_res_t;

	typedef struct packed {
		logic [31:0] quo;
		logic        ovf;
		logic        neg;
		logic        dz;
		logic        bneg;
	} div_res_t;

	// clip a wide signed value into 32 bits
	function automatic sat_val_t clip66(input logic signed [SUM_W-1:0] v);
		sat_val_t         o;
		logic [SUM_W-32:0] hi;
		hi = v[SUM_W-1:31];
		if (hi == '0 || hi == '1) begin
			o.val = v[31:0];
			o.sat = 1'b0;
		end else begin
			o.val = v[SUM_W-1] ? S32_MIN : S32_MAX;
			o.sat = 1'b1;
		end
		return o;
	endfunction

endpackage

// ----- hw/rtl/qalu_if.sv -----
`timescale 1ns / 1ps
// qalu_req_if / qalu_rsp_if: valid/ready channels of the quaternion arithmetic unit
// no dependencies
interface qalu_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic signed [31:0] b_w;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] c_w;
	logic signed [31:0] c_x;
	logic signed [31:0] c_y;
	logic signed [31:0] c_z;
	logic signed [31:0] scalar;
	modport source (output valid, op, b_w, b_x, b_y, b_z, c_w, c_x, c_y, c_z, scalar,
		input ready);
	modport sink (input valid, op, b_w, b_x, b_y, b_z, c_w, c_x, c_y, c_z, scalar,
		output ready);
endinterface

interface qalu_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] r_w;
	logic signed [31:0] r_x;
	logic signed [31:0] r_y;
	logic signed [31:0] r_z;
	logic               saturated;
	logic               div_zero;
	modport source (output valid, r_w, r_x, r_y, r_z, saturated, div_zero, input ready);
	modport sink (input valid, r_w, r_x, r_y, r_z, saturated, div_zero, output ready);
endinterface

// ----- hw/rtl/quaternion_alu.sv -----
`timescale 1ns / 1ps
// quaternion_alu: top level, request register, four part lanes, norm unit, merge
// depends on qalu_pkg, qalu_if, qalu_lane, qalu_sqrt
//
// Takes one request per clock unless the pipeline is held, and returns one response
// per request, in order, through the registered request, the divider's setup stage and
// its 32 quotient-bit stages in each lane (the product and sum stages run alongside),
// the lane result and the output register. Each of the four lanes computes one part of
// the result; lane 0 also feeds the 31-stage square root used by the norm. When the
// response is held by the sink, the whole pipeline holds, so throughput follows the sink.
// All values are signed fixed point with FRAC_BITS fraction bits; clipped
// results raise saturated, and a divide by zero raises div_zero as well.
module quaternion_alu #(
	parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	qalu_req_if.sink          req,
	qalu_rsp_if.source        rsp
);
	import qalu_pkg::*;

	logic                    en;
	logic [PIPE_DEPTH-1:0]   vld_q;
	logic signed [31:0]      bq [NUM_LANES];
	logic signed [31:0]      cq [NUM_LANES];
	op_t                     req_op;
	lane_req_t               lreq    [NUM_LANES];
	lane_req_t               lreq_s1 [NUM_LANES];
	lane_res_t               lres    [NUM_LANES];
	logic signed [SUM_W-1:0] lsum    [NUM_LANES];
	sat_val_t                norm_res;
	logic signed [31:0]      r_d [NUM_LANES];
	logic signed [31:0]      r_q [NUM_LANES];
	logic                    sat_d;
	logic                    dz_d;
	logic                    sat_q;
	logic                    dz_q;
	logic                    out_v_q;
	op_t                     op_q;

	// pipeline advances unless a response is waiting
	assign en        = !out_v_q || rsp.ready;
	assign req.ready = en;

	// operand routing per lane
	always_comb begin
		bq[0]  = req.b_w;
		bq[1]  = req.b_x;
		bq[2]  = req.b_y;
		bq[3]  = req.b_z;
		cq[0]  = req.c_w;
		cq[1]  = req.c_x;
		cq[2]  = req.c_y;
		cq[3]  = req.c_z;
		req_op = op_t'(req.op);
		for (int l = 0; l < NUM_LANES; l++) begin
			lreq[l]         = '0;
			lreq[l].op      = req_op;
			lreq[l].add_a   = bq[l];
			lreq[l].add_b   = cq[l];
			lreq[l].div_num = bq[l];
			lreq[l].div_den = req.scalar;
			unique case (req_op)
				OP_MUL: begin
					lreq[l].mul_neg = HAM_NEG[l];
					for (int k = 0; k < NUM_LANES; k++) begin
						lreq[l].mul_a[k] = bq[k];
						lreq[l].mul_b[k] = cq[2'(l ^ k)];
					end
				end
				OP_SCALE: begin
					lreq[l].mul_a[0] = req.scalar;
					lreq[l].mul_b[0] = bq[l];
				end
				OP_NSQ, OP_NORM: begin
					for (int k = 0; k < NUM_LANES; k++) begin
						lreq[l].mul_a[k] = bq[k];
						lreq[l].mul_b[k] = bq[k];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request valid tracking and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q   <= {vld_q[PIPE_DEPTH-2:0], req.valid};
			out_v_q <= vld_q[PIPE_DEPTH-1];
		end
	end

	// stage 1 request register
	always_ff @(posedge clk) begin
		if (en) begin
			lreq_s1 <= lreq;
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		qalu_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.en     (en),
			.req    (lreq_s1[l]),
			.res    (lres[l]),
			.sum_sq (lsum[l])
		);
	end

	qalu_sqrt u_sqrt (
		.clk (clk),
		.en  (en),
		.sum (lsum[0]),
		.res (norm_res)
	);

	// merge lane results
	always_comb begin
		sat_d = 1'b0;
		dz_d  = 1'b0;
		for (int l = 0; l < NUM_LANES; l++) begin
			r_d[l] = '0;
		end
		unique case (lres[0].op)
			OP_NSQ: begin
				r_d[0] = lres[0].val;
				sat_d  = lres[0].sat;
			end
			OP_NORM: begin
				r_d[0] = norm_res.val;
				sat_d  = norm_res.sat;
			end
			OP_NOP: begin
			end
			default: begin
				for (int l = 0; l < NUM_LANES; l++) begin
					r_d[l] = lres[l].val;
					sat_d  = sat_d | lres[l].sat;
				end
				dz_d = lres[0].dz;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			r_q   <= r_d;
			sat_q <= sat_d;
			dz_q  <= dz_d;
			op_q  <= lres[0].op;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.r_w       = r_q[0];
	assign rsp.r_x       = r_q[1];
	assign rsp.r_y       = r_q[2];
	assign rsp.r_z       = r_q[3];
	assign rsp.saturated = sat_q;
	assign rsp.div_zero  = dz_q;

	// checks
	a_dz_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.div_zero |-> rsp.saturated)
		else $error("div_zero without saturated");

	a_dz_op: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.div_zero |-> op_q == OP_DIV)
		else $error("div_zero on an op other than divide");

	a_norm_parts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (op_q == OP_NSQ || op_q == OP_NORM || op_q == OP_NOP)
		|-> r_q[1] == '0 && r_q[2] == '0 && r_q[3] == '0)
		else $error("nonzero vector part on a scalar result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during stall");

endmodule

// ----- hw/rtl/qalu_div.sv -----
`timescale 1ns / 1ps
// qalu_div: pipelined restoring divider, one quotient bit per stage
// depends on qalu_pkg
module qalu_div #(
	parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output qalu_pkg::div_res_t res
);
	import qalu_pkg::*;

	localparam int NW = 32 + FRAC_BITS + 1;

	typedef struct packed {
		logic ovf;
		logic neg;
		logic dz;
		logic bneg;
	} dflag_t;

	logic [31:0]   mag_n;
	logic [31:0]   mag_d;
	logic [NW-1:0] dvd;
	dflag_t        flg;

	logic [31:0] rem_q [DIV_STEPS];
	logic [31:0] lo_q  [DIV_STEPS];
	logic [31:0] den_q [DIV_STEPS];
	logic [31:0] quo_q [DIV_STEPS+1];
	dflag_t      flg_q [DIV_STEPS+1];

	// magnitudes, rounding offset and early overflow check
	always_comb begin
		mag_n    = num[31] ? (~num + 32'd1) : num;
		mag_d    = den[31] ? (~den + 32'd1) : den;
		dvd      = (NW'(mag_n) << FRAC_BITS) + NW'(mag_d >> 1);
		flg.ovf  = 32'(dvd[NW-1:32]) >= mag_d;
		flg.neg  = num[31] ^ den[31];
		flg.dz   = (den == 32'sd0);
		flg.bneg = num[31];
	end

	// setup stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= 32'(dvd[NW-1:32]);
			lo_q[0]  <= dvd[31:0];
			den_q[0] <= mag_d;
			quo_q[0] <= '0;
			flg_q[0] <= flg;
		end
	end

	// one quotient bit per stage
	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
		logic [32:0] trial;
		logic        ge;
		assign trial = {rem_q[j-1], lo_q[j-1][31]};
		assign ge    = trial >= {1'b0, den_q[j-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[j] <= {quo_q[j-1][30:0], ge};
				flg_q[j] <= flg_q[j-1];
			end
		end

		if (j < DIV_STEPS) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= ge ? 32'(trial - {1'b0, den_q[j-1]}) : trial[31:0];
					lo_q[j]  <= {lo_q[j-1][30:0], 1'b0};
					den_q[j] <= den_q[j-1];
				end
			end
		end
	end

	always_comb begin
		res.quo  = quo_q[DIV_STEPS];
		res.ovf  = flg_q[DIV_STEPS].ovf;
		res.neg  = flg_q[DIV_STEPS].neg;
		res.dz   = flg_q[DIV_STEPS].dz;
		res.bneg = flg_q[DIV_STEPS].bneg;
	end

endmodule

// ----- hw/rtl/qalu_sqrt.sv -----
`timescale 1ns / 1ps
// qalu_sqrt: pipelined integer square root of the sum of squares, rounded and clipped
// depends on qalu_pkg
module qalu_sqrt (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [qalu_pkg::SUM_W-1:0]   sum,
	output qalu_pkg::sat_val_t                  res
);
	import qalu_pkg::*;

	localparam int RW = 62;

	logic [RW-1:0] v_q   [SQRT_STEPS];
	logic [RW-1:0] r_q   [SQRT_STEPS];
	logic          big_q [SQRT_STEPS];
	logic [32:0]   qr;
	sat_val_t      res_q;

	// one root bit per stage, from the top pair of bits down
	for (genvar t = 0; t < SQRT_STEPS; t++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - t));
		logic [RW-1:0] v_in;
		logic [RW-1:0] r_in;
		logic [RW-1:0] trial;
		logic          big_in;

		if (t == 0) begin : g_first
			assign v_in   = sum[RW-1:0];
			assign r_in   = '0;
			assign big_in = (sum[SUM_W-1:RW] != '0);
		end else begin : g_next
			assign v_in   = v_q[t-1];
			assign r_in   = r_q[t-1];
			assign big_in = big_q[t-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= trial) begin
					v_q[t] <= v_in - trial;
					r_q[t] <= (r_in >> 1) + BIT;
				end else begin
					v_q[t] <= v_in;
					r_q[t] <= r_in >> 1;
				end
				big_q[t] <= big_in;
			end
		end
	end

	// round to nearest with the remainder, then clip
	assign qr = {1'b0, r_q[SQRT_STEPS-1][31:0]}
		+ 33'(v_q[SQRT_STEPS-1] > r_q[SQRT_STEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (big_q[SQRT_STEPS-1] || qr[32] || qr[31]) begin
				res_q.val <= S32_MAX;
				res_q.sat <= 1'b1;
			end else begin
				res_q.val <= qr[31:0];
				res_q.sat <= 1'b0;
			end
		end
	end

	assign res = res_q;

endmodule

// ----- hw/rtl/qalu_lane.sv -----
`timescale 1ns / 1ps
// qalu_lane: one result part: add/sub, four-term product sum, and scalar divide
// depends on qalu_pkg and qalu_div
module qalu_lane #(
	parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  qalu_pkg::lane_req_t                 req,
	output qalu_pkg::lane_res_t                 res,
	output logic signed [qalu_pkg::SUM_W-1:0]   sum_sq
);
	import qalu_pkg::*;

	localparam int FAST_DLY = DIV_STEPS - 2;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		op_t      op;
		sat_val_t sv;
	} fast_t;

	logic signed [32:0]      as_raw;
	sat_val_t                as_cl;
	logic signed [63:0]      prod_s2 [NUM_LANES];
	logic [NUM_LANES-1:0]    neg_s2;
	op_t                     op_s2;
	op_t                     op_s3;
	sat_val_t                as_s2;
	sat_val_t                as_s3;
	logic signed [SUM_W-1:0] acc;
	logic signed [SUM_W-1:0] sum_s3;
	logic signed [SUM_W-1:0] rnd;
	fast_t                   fast_s4;
	fast_t                   fast_q [FAST_DLY];
	div_res_t                dres;
	sat_val_t                div_cl;
	lane_res_t               res_s35;

	// add or subtract with clipping
	always_comb begin
		if (req.op == OP_SUB) begin
			as_raw = {req.add_a[31], req.add_a} - {req.add_b[31], req.add_b};
		end else begin
			as_raw = {req.add_a[31], req.add_a} + {req.add_b[31], req.add_b};
		end
		as_cl = clip66({{(SUM_W-33){as_raw[32]}}, as_raw});
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= req.op;
			as_s2  <= as_cl;
			neg_s2 <= req.mul_neg;
			for (int k = 0; k < NUM_LANES; k++) begin
				prod_s2[k] <= $signed(req.mul_a[k]) * $signed(req.mul_b[k]);
			end
		end
	end

	// signed sum of the four products
	always_comb begin
		acc = '0;
		for (int k = 0; k < NUM_LANES; k++) begin
			if (neg_s2[k]) begin
				acc = acc - {{(SUM_W-64){prod_s2[k][63]}}, prod_s2[k]};
			end else begin
				acc = acc + {{(SUM_W-64){prod_s2[k][63]}}, prod_s2[k]};
			end
		end
	end

	// stage 3: exact sum
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= acc;
			op_s3  <= op_s2;
			as_s3  <= as_s2;
		end
	end

	// round half up and drop the fraction
	assign rnd = (sum_s3 + HALF) >>> FRAC_BITS;

	// stage 4: short-path result, then delay to meet the divider
	always_ff @(posedge clk) begin
		if (en) begin
			fast_s4.op <= op_s3;
			fast_s4.sv <= (op_s3 == OP_ADD || op_s3 == OP_SUB) ? as_s3 : clip66(rnd);
			fast_q[0]  <= fast_s4;
			for (int j = 1; j < FAST_DLY; j++) begin
				fast_q[j] <= fast_q[j-1];
			end
		end
	end

	qalu_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk (clk),
		.en  (en),
		.num (req.div_num),
		.den (req.div_den),
		.res (dres)
	);

	// quotient sign and clipping
	always_comb begin
		div_cl.sat = 1'b1;
		if (dres.dz) begin
			div_cl.val = dres.bneg ? S32_MIN : S32_MAX;
		end else if (dres.ovf) begin
			div_cl.val = dres.neg ? S32_MIN : S32_MAX;
		end else if (dres.neg) begin
			if (dres.quo > 32'h8000_0000) begin
				div_cl.val = S32_MIN;
			end else begin
				div_cl.val = 32'd0 - dres.quo;
				div_cl.sat = 1'b0;
			end
		end else if (dres.quo[31]) begin
			div_cl.val = S32_MAX;
		end else begin
			div_cl.val = dres.quo;
			div_cl.sat = 1'b0;
		end
	end

	// lane result
	always_ff @(posedge clk) begin
		if (en) begin
			res_s35.op <= fast_q[FAST_DLY-1].op;
			if (fast_q[FAST_DLY-1].op == OP_DIV) begin
				res_s35.val <= div_cl.val;
				res_s35.sat <= div_cl.sat;
				res_s35.dz  <= dres.dz;
			end else begin
				res_s35.val <= fast_q[FAST_DLY-1].sv.val;
				res_s35.sat <= fast_q[FAST_DLY-1].sv.sat;
				res_s35.dz  <= 1'b0;
			end
		end
	end

	assign res    = res_s35;
	assign sum_sq = sum_s3;

endmodule
